/* src/bds_pkg.sv */
// Shared types and constants of the 2x2 box downsampler.
`timescale 1ns / 1ps

package bds_pkg;

    localparam int CH_W       = 8;          // bits per color channel
    localparam int SUM_W      = CH_W + 1;   // sum of two channel values
    localparam int LINE_W     = 3 * SUM_W;  // one line store entry: three pair sums
    localparam int POS_W      = 11;         // output column / row
    localparam int CFG_W      = 12;         // configuration data
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [SUM_W-1:0]  t_pair;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CFG_W-1:0]  t_cfg;

    // Item between the front end and the output stage. In pass-through
    // mode the pair fields carry the raw pixel, zero extended.
    typedef struct packed {
        logic  pass;
        t_pair pair_r;
        t_pair pair_g;
        t_pair pair_b;
        t_pos  col;
        t_pos  row;
        logic  last;
    } t_s1;

endpackage

/* src/bds_line_mem.sv */
// Half-row line store of pair sums: one write port, one registered read port.
`timescale 1ns / 1ps

module bds_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 27
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bds_ctrl.sv */
// Front end: sizes, raster counters, left pixel, pair sums, line store access.
`timescale 1ns / 1ps

module bds_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bds_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  bds_pkg::t_cfg                     i_cfg_data,
    input  logic                              i_pix_valid,
    output logic                              o_pix_ready,
    input  bds_pkg::t_chan                    i_red,
    input  bds_pkg::t_chan                    i_green,
    input  bds_pkg::t_chan                    i_blue,
    input  logic                              i_s1_take,
    output logic                              o_s1_valid,
    output bds_pkg::t_s1                      o_s1,
    output logic                              o_mem_we,
    output logic                              o_mem_re,
    output logic [$clog2(MAX_WIDTH/2)-1:0]    o_mem_addr,
    output logic [bds_pkg::LINE_W-1:0]        o_mem_wdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSW = $clog2(MAX_WIDTH + 1);
    localparam int HSW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_WIDTH / 2);
    localparam int W_RST = (bds_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : bds_pkg::WIDTH_RESET;
    localparam int H_RST = (bds_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : bds_pkg::HEIGHT_RESET;

    logic [WSW-1:0]   r_width;
    logic [HSW-1:0]   r_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    bds_pkg::t_chan   r_left_r, r_left_g, r_left_b;
    logic             r_s1_valid;
    bds_pkg::t_s1     r_s1;
    bds_pkg::t_s1     n_s1;

    logic             accept;
    logic [31:0]      cfg32;
    logic [WSW-1:0]   c_ext, c_nxt, used_w, w_half, idx_inc;
    logic [HSW-1:0]   r_ext, r_nxt, used_h, h_half, rh_inc;
    logic [CW-2:0]    idx;
    logic [RW-2:0]    rh;
    logic             pass, in_area, col_end, row_end;
    logic             do_left, do_write, do_read;
    bds_pkg::t_pair   pair_r, pair_g, pair_b;

    // ---- configuration, clamped on write: 0 acts as 1, oversize saturates
    assign cfg32 = 32'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WSW'(W_RST);
            r_height <= HSW'(H_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bds_pkg::REG_IMAGE_WIDTH: begin
                    if (cfg32 == 32'd0)                   r_width <= WSW'(1);
                    else if (cfg32 > 32'(MAX_WIDTH))      r_width <= WSW'(MAX_WIDTH);
                    else                                  r_width <= WSW'(cfg32);
                end
                bds_pkg::REG_IMAGE_HEIGHT: begin
                    if (cfg32 == 32'd0)                   r_height <= HSW'(1);
                    else if (cfg32 > 32'(MAX_HEIGHT))     r_height <= HSW'(MAX_HEIGHT);
                    else                                  r_height <= HSW'(cfg32);
                end
                default: begin
                end
            endcase
        end
    end

    // ---- position decode
    assign c_ext   = WSW'(r_col);
    assign c_nxt   = c_ext + 1'b1;
    assign r_ext   = HSW'(r_row);
    assign r_nxt   = r_ext + 1'b1;
    assign used_w  = {r_width[WSW-1:1], 1'b0};
    assign used_h  = {r_height[HSW-1:1], 1'b0};
    assign w_half  = r_width >> 1;
    assign h_half  = r_height >> 1;
    assign idx     = r_col[CW-1:1];
    assign rh      = r_row[RW-1:1];
    assign idx_inc = WSW'(idx) + 1'b1;
    assign rh_inc  = HSW'(rh) + 1'b1;

    assign pass    = (r_width <= WSW'(2)) || (r_height <= HSW'(2));
    assign in_area = (c_ext < used_w) && (r_ext < used_h);
    assign col_end = c_nxt >= r_width;
    assign row_end = r_nxt >= r_height;

    assign do_left  = !pass && in_area && !r_col[0];
    assign do_write = !pass && in_area && r_col[0] && !r_row[0];
    assign do_read  = !pass && in_area && r_col[0] && r_row[0];

    assign pair_r = bds_pkg::SUM_W'(r_left_r) + bds_pkg::SUM_W'(i_red);
    assign pair_g = bds_pkg::SUM_W'(r_left_g) + bds_pkg::SUM_W'(i_green);
    assign pair_b = bds_pkg::SUM_W'(r_left_b) + bds_pkg::SUM_W'(i_blue);

    assign o_pix_ready = !r_s1_valid || i_s1_take;
    assign accept      = i_pix_valid && o_pix_ready;

    // ---- line store: even rows write, odd rows read the same column pair.
    // A write and a read of one entry are always at least a row apart.
    assign o_mem_we    = accept && do_write;
    assign o_mem_re    = accept && do_read;
    assign o_mem_addr  = idx[AW-1:0];
    assign o_mem_wdata = {pair_b, pair_g, pair_r};

    // ---- raster counters and left pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left_r <= '0;
            r_left_g <= '0;
            r_left_b <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : RW'(r_nxt);
            end else begin
                r_col <= CW'(c_nxt);
                if (r_ext >= r_height) begin
                    r_row <= '0;
                end
            end
            if (do_left) begin
                r_left_r <= i_red;
                r_left_g <= i_green;
                r_left_b <= i_blue;
            end
        end
    end

    // ---- stage 1: result meta, lines up with line store read data
    always_comb begin
        n_s1 = '0;
        if (pass) begin
            n_s1.pass   = 1'b1;
            n_s1.pair_r = bds_pkg::SUM_W'(i_red);
            n_s1.pair_g = bds_pkg::SUM_W'(i_green);
            n_s1.pair_b = bds_pkg::SUM_W'(i_blue);
            n_s1.col    = bds_pkg::t_pos'(r_col);
            n_s1.row    = bds_pkg::t_pos'(r_row);
            n_s1.last   = col_end && row_end;
        end else begin
            n_s1.pass   = 1'b0;
            n_s1.pair_r = pair_r;
            n_s1.pair_g = pair_g;
            n_s1.pair_b = pair_b;
            n_s1.col    = bds_pkg::t_pos'(idx);
            n_s1.row    = bds_pkg::t_pos'(rh);
            n_s1.last   = (idx_inc >= w_half) && (rh_inc >= h_half);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pix_ready) begin
            r_s1_valid <= accept && (pass || do_read);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    // ---- checks
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("line store read and write in one cycle");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_re |=> r_s1_valid)
        else $error("line store read without a result in stage 1");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |=> !r_s1_valid)
        else $error("even-row item left a result in stage 1");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pix_ready |-> (r_s1_valid && !i_s1_take))
        else $error("input stalled while stage 1 can move");

endmodule

/* src/bds_out.sv */
// Output stage: vertical add of pair sums, divide by four (raw pixel in pass-through), output register.
`timescale 1ns / 1ps

module bds_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_valid,
    input  bds_pkg::t_s1               i_s1,
    input  logic [bds_pkg::LINE_W-1:0] i_above,
    output logic                       o_s1_take,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bds_pkg::t_chan             o_red,
    output bds_pkg::t_chan             o_green,
    output bds_pkg::t_chan             o_blue,
    output bds_pkg::t_pos              o_col,
    output bds_pkg::t_pos              o_row,
    output logic                       o_last
);

    localparam int SW = bds_pkg::SUM_W;

    logic [SW:0]    sum_r, sum_g, sum_b;
    bds_pkg::t_chan n_red, n_green, n_blue;
    logic           r_valid;
    bds_pkg::t_chan r_red, r_green, r_blue;
    bds_pkg::t_pos  r_col, r_row;
    logic           r_last;

    assign sum_r = {1'b0, i_above[SW-1:0]}      + {1'b0, i_s1.pair_r};
    assign sum_g = {1'b0, i_above[2*SW-1:SW]}   + {1'b0, i_s1.pair_g};
    assign sum_b = {1'b0, i_above[3*SW-1:2*SW]} + {1'b0, i_s1.pair_b};

    // truncated mean of four = sum >> 2
    assign n_red   = i_s1.pass ? i_s1.pair_r[bds_pkg::CH_W-1:0] : sum_r[SW:2];
    assign n_green = i_s1.pass ? i_s1.pair_g[bds_pkg::CH_W-1:0] : sum_g[SW:2];
    assign n_blue  = i_s1.pass ? i_s1.pair_b[bds_pkg::CH_W-1:0] : sum_b[SW:2];

    assign o_s1_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_take) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take && i_s1_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_col   <= i_s1.col;
            r_row   <= i_s1.row;
            r_last  <= i_s1.last;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_last  = r_last;

endmodule

/* src/box_downsample_2x2.sv */
// Top level of the 2x2 box-filter downsampler for RGB raster streams.
`timescale 1ns / 1ps

// Takes one RGB pixel per item in raster order and emits one pixel per 2x2
// block, each channel being the truncated mean (sum of four) >> 2, tagged
// with its output column and row; tlast marks the final result of a frame.
// The even row's horizontal pair sums wait in a half-row line store (one
// synchronous RAM of MAX_WIDTH/2 x 27 bits) and are read back when the odd
// row below arrives. An odd last column or odd last row gives no result.
// If width or height is 2 or less every pixel passes straight through with
// its own column and row. A size of 0 acts as 1, sizes above MAX_WIDTH /
// MAX_HEIGHT saturate. Throughput is one item per clock unless m_axis_tready
// stalls the output: the line store has a separate read and write port and
// a read and write of one entry are always a row apart. An accepted input
// passes the line store read stage, then the output register. The line store
// is not cleared after reset and needs none: every entry is written by an even
// row before it is read. Write sizes only while the block is idle, ideally
// between frames; the raster counters are not reset by a write.
module box_downsample_2x2 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [bds_pkg::CFG_ADDR_W-1:0] i_cfg_addr,   // 0 image_width, 1 image_height
    input  logic [bds_pkg::CFG_W-1:0]      i_cfg_data,
    // input pixels
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata, // pixel_red, pixel_green, pixel_blue
    // results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata, // out_red, out_green, out_blue,
                                                         // out_col, out_row, 2 bits zero
    output logic                           m_axis_tlast  // frame_last
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);

    logic                       s1_valid, s1_take;
    bds_pkg::t_s1               s1;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_addr;
    logic [bds_pkg::LINE_W-1:0] mem_wdata, mem_rdata;
    bds_pkg::t_chan             out_red, out_green, out_blue;
    bds_pkg::t_pos              out_col, out_row;

    bds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_red       (s_axis_tdata[7:0]),
        .i_green     (s_axis_tdata[15:8]),
        .i_blue      (s_axis_tdata[23:16]),
        .i_s1_take   (s1_take),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    // same address serves both ports: a cycle is either a write or a read
    bds_line_mem #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW),
        .DW    (bds_pkg::LINE_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    bds_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_above    (mem_rdata),
        .o_s1_take  (s1_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_red      (out_red),
        .o_green    (out_green),
        .o_blue     (out_blue),
        .o_col      (out_col),
        .o_row      (out_row),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_row, out_col, out_blue, out_green, out_red};

endmodule
